>>> rtl/grid_q_learning_update_assert.svh
// Assertion macros used by the port checker of the grid Q-learning update block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef GRID_Q_LEARNING_UPDATE_ASSERT_SVH
`define GRID_Q_LEARNING_UPDATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GQLU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GQLU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/gqlu_pkg.sv
// Types and constants of the grid Q-learning update block.
// Used by grid_q_learning_update and the testbench; depends on nothing else.
package gqlu_pkg;

	localparam int CELL_IN_W  = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;
	localparam int MAP_W      = 18;
	localparam int MAP_CELLS  = MAP_W / 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MAZE_MAP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_REWARD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_REWARD = 3'd4;

	// Register values after reset.
	localparam logic [MAP_W-1:0]   MAZE_MAP_RST    = 18'd4104;
	localparam logic [15:0]        LEARN_RATE_RST  = 16'd6554;
	localparam logic [15:0]        DISCOUNT_RST    = 16'd58982;
	localparam logic signed [15:0] GOAL_REWARD_RST = 16'sd100;
	localparam logic signed [15:0] WALL_REWARD_RST = -16'sd5;

	// Cell kinds in the maze map.
	localparam logic [1:0] KIND_OPEN     = 2'd0;
	localparam logic [1:0] KIND_WALL     = 2'd1;
	localparam logic [1:0] KIND_GOAL     = 2'd2;
	localparam logic [1:0] KIND_WALL_ALT = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_UPDATED   = 2'd0;
	localparam logic [1:0] STAT_NOT_ADJ   = 2'd1;
	localparam logic [1:0] STAT_FROM_GOAL = 2'd2;

	// Neighbor directions.
	localparam logic [1:0] NBR_UP    = 2'd0;
	localparam logic [1:0] NBR_DOWN  = 2'd1;
	localparam logic [1:0] NBR_LEFT  = 2'd2;
	localparam logic [1:0] NBR_RIGHT = 2'd3;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [CELL_IN_W-1:0] from_cell;
		logic [CELL_IN_W-1:0] to_cell;
	} gqlu_cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] q_value;
		logic               next_is_goal;
	} gqlu_result_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_MULG,
		S_DELTA,
		S_MULA,
		S_WB
	} gqlu_state_t;

	// Kind of cell k; cells whose bits lie beyond the map read as open.
	function automatic logic [1:0] cell_kind(input logic [MAP_W-1:0] map, input logic [7:0] k);
		logic [MAP_W-1:0] s;
		s = map >> {k, 1'b0};
		return (k < 8'(MAP_CELLS)) ? s[1:0] : KIND_OPEN;
	endfunction

endpackage

>>> rtl/grid_q_learning_update.sv
// Top level of the grid Q-learning update block: sequencer, Q table memory and
// one shared multiplier. Depends on gqlu_pkg.
//
// Usage: a command word (from_cell, to_cell) is taken at a rising edge where
// start is high and busy is low. busy stays high until the result word is
// shown; the result sits on result for exactly one cycle with done high and
// the receiver cannot hold it off. A new command may be started in the cycle
// in which done is high.
// The block reads the Q entry and the four neighbor entries of the to-cell
// through the single read port of the Q table, one per cycle, then runs
// gamma*max and alpha*delta one after the other through one 17x34 multiplier;
// a rejected move goes back to idle without the multiplies. A new command is
// taken only once the result word of the last one has been shown.
// The user writes configuration via cfg_wr_en/cfg_index/cfg_wdata only while
// no command is in flight (not enforced by the block); unknown indexes are ignored.
// Reset: registers return to their defaults and the Q table is cleared by a
// pass that writes one entry per cycle over all (GRID_ROWS*GRID_COLS)^2 entries
// (81 at the default size), during which busy is high.
module grid_q_learning_update #(
	parameter int GRID_ROWS = 3,
	parameter int GRID_COLS = 3
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [gqlu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gqlu_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                start,
	input  gqlu_pkg::gqlu_cmd_t                 cmd,
	output logic                                busy,
	output logic                                done,
	output gqlu_pkg::gqlu_result_t              result
);
	import gqlu_pkg::*;

	localparam int CELLS = GRID_ROWS * GRID_COLS;
	localparam int DEPTH = CELLS * CELLS;
	localparam int CW    = $clog2(CELLS);
	localparam int NW    = ((CW > CELL_IN_W) ? CW : CELL_IN_W) + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [2:0] SCAN_Q_DATA = 3'd1;
	localparam logic [2:0] SCAN_LAST   = 3'd5;

	// Column of a cell, as a small constant table.
	function automatic logic [NW-1:0] col_of(input logic [NW-1:0] c);
		logic [NW-1:0] col;
		col = '0;
		for (int i = 0; i < CELLS; i++) begin
			if (c == NW'(i)) begin
				col = NW'(i % GRID_COLS);
			end
		end
		return col;
	endfunction

	// Neighbor of cell c in direction k: {valid, index}.
	function automatic logic [NW:0] nbr_of(input logic [NW-1:0] c, input logic [1:0] k);
		logic [NW-1:0] col;
		logic [NW-1:0] n;
		logic          ok;
		col = col_of(c);
		n   = '0;
		ok  = 1'b0;
		unique case (k)
			NBR_UP: begin
				n  = c - NW'(GRID_COLS);
				ok = (c >= NW'(GRID_COLS));
			end
			NBR_DOWN: begin
				n  = c + NW'(GRID_COLS);
				ok = (n < NW'(CELLS));
			end
			NBR_LEFT: begin
				n  = c - NW'(1);
				ok = (col != '0);
			end
			NBR_RIGHT: begin
				n  = c + NW'(1);
				ok = (col != NW'(GRID_COLS - 1));
			end
		endcase
		return {ok, n};
	endfunction

	gqlu_state_t state_q, state_d;

	logic [2:0]          scan_q;
	logic [AW-1:0]       clr_q;
	logic                done_q;
	gqlu_result_t        res_q;

	logic [MAP_W-1:0]    maze_q;
	logic [15:0]         lr_q;
	logic [15:0]         disc_q;
	logic signed [15:0]  goal_rw_q;
	logic signed [15:0]  wall_rw_q;

	logic [NW-1:0]       f_q, t_q;
	logic [1:0]          t_kind_q;
	logic [1:0]          stat_q;
	logic                goal_q;
	logic                pair_ok_q;
	logic signed [31:0]  q_q;
	logic signed [31:0]  max_q;
	logic signed [33:0]  delta_q;
	logic signed [50:0]  prod_q;

	logic signed [31:0]  mem [DEPTH];
	logic signed [31:0]  rdata_q;

	// Command decode at the accepting edge.
	logic [NW-1:0]       in_f, in_t;
	logic                f_ok, t_ok, adj;
	logic [1:0]          f_kind, t_kind;
	logic [1:0]          in_stat;
	logic [NW:0]         adj_nb;

	// Control from the output decode.
	logic                accept;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic signed [31:0]  mem_wdata;
	logic [AW-1:0]       rd_addr;
	logic                mul_gamma;
	logic                fin_noupd;
	logic                fin_upd;

	// Datapath.
	logic [NW:0]         iss_nb, con_nb;
	logic [AW-1:0]       q_addr, nb_addr;
	logic signed [16:0]  mul_a;
	logic signed [33:0]  mul_b;
	logic signed [50:0]  mul_p;
	logic signed [15:0]  reward;
	logic signed [33:0]  gm;
	logic signed [33:0]  delta_d;
	logic signed [34:0]  step;
	logic signed [35:0]  nq;
	logic signed [31:0]  q_sat;

	always_comb begin
		in_f   = NW'(cmd.from_cell);
		in_t   = NW'(cmd.to_cell);
		f_ok   = in_f < NW'(CELLS);
		t_ok   = in_t < NW'(CELLS);
		f_kind = cell_kind(maze_q, 8'(in_f));
		t_kind = cell_kind(maze_q, 8'(in_t));
		adj    = 1'b0;
		adj_nb = '0;
		for (int k = 0; k < 4; k++) begin
			adj_nb = nbr_of(in_f, 2'(k));
			if (adj_nb[NW] && adj_nb[NW-1:0] == in_t) begin
				adj = 1'b1;
			end
		end
		priority if (f_ok && f_kind == KIND_GOAL) begin
			in_stat = STAT_FROM_GOAL;
		end else if (!f_ok || !t_ok || !adj) begin
			in_stat = STAT_NOT_ADJ;
		end else begin
			in_stat = STAT_UPDATED;
		end
	end

	// Read addresses: the entry itself first, then the to-cell's four moves.
	always_comb begin
		iss_nb  = nbr_of(t_q, 2'(scan_q - 3'd1));
		con_nb  = nbr_of(t_q, 2'(scan_q - 3'd2));
		q_addr  = AW'(f_q) * AW'(CELLS) + AW'(t_q);
		nb_addr = AW'(t_q) * AW'(CELLS) + AW'(iss_nb[NW-1:0]);
		rd_addr = (scan_q == 3'd0) ? q_addr : nb_addr;
	end

	// Shared multiplier: gamma * max first, then alpha * delta.
	always_comb begin
		if (mul_gamma) begin
			mul_a = $signed({1'b0, disc_q});
			mul_b = 34'(max_q);
		end else begin
			mul_a = $signed({1'b0, lr_q});
			mul_b = delta_q;
		end
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		unique case (t_kind_q)
			KIND_OPEN:     reward = '0;
			KIND_GOAL:     reward = goal_rw_q;
			KIND_WALL:     reward = wall_rw_q;
			KIND_WALL_ALT: reward = wall_rw_q;
		endcase
		gm      = 34'((prod_q + 51'sd32768) >>> 16);
		delta_d = (34'(reward) <<< 16) + gm - 34'(q_q);
		step    = 35'((prod_q + 51'sd32768) >>> 16);
		nq      = 36'(q_q) + 36'(step);
		if (nq > 36'(Q_MAX)) begin
			q_sat = Q_MAX;
		end else if (nq < 36'(Q_MIN)) begin
			q_sat = Q_MIN;
		end else begin
			q_sat = 32'(nq);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_q == SCAN_LAST) begin
					state_d = (stat_q == STAT_UPDATED) ? S_MULG : S_IDLE;
				end
			end
			S_MULG:  state_d = S_DELTA;
			S_DELTA: state_d = S_MULA;
			S_MULA:  state_d = S_WB;
			S_WB:    state_d = S_IDLE;
		endcase
	end

	// Output decode.
	always_comb begin
		busy      = 1'b1;
		accept    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = q_addr;
		mem_wdata = q_sat;
		mul_gamma = 1'b0;
		fin_noupd = 1'b0;
		fin_upd   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_IDLE: begin
				busy   = 1'b0;
				accept = start;
			end
			S_SCAN: begin
				fin_noupd = (scan_q == SCAN_LAST) && (stat_q != STAT_UPDATED);
			end
			S_MULG: begin
				mul_gamma = 1'b1;
			end
			S_DELTA: begin
			end
			S_MULA: begin
			end
			S_WB: begin
				mem_we  = 1'b1;
				fin_upd = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			scan_q    <= '0;
			clr_q     <= '0;
			done_q    <= 1'b0;
			maze_q    <= MAZE_MAP_RST;
			lr_q      <= LEARN_RATE_RST;
			disc_q    <= DISCOUNT_RST;
			goal_rw_q <= GOAL_REWARD_RST;
			wall_rw_q <= WALL_REWARD_RST;
		end else begin
			state_q <= state_d;
			done_q  <= fin_noupd | fin_upd;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept) begin
				scan_q <= '0;
			end else if (state_q == S_SCAN) begin
				scan_q <= scan_q + 3'd1;
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_MAZE_MAP:    maze_q    <= cfg_wdata;
					REG_LEARN_RATE:  lr_q      <= cfg_wdata[15:0];
					REG_DISCOUNT:    disc_q    <= cfg_wdata[15:0];
					REG_GOAL_REWARD: goal_rw_q <= $signed(cfg_wdata[15:0]);
					REG_WALL_REWARD: wall_rw_q <= $signed(cfg_wdata[15:0]);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			f_q       <= in_f;
			t_q       <= in_t;
			t_kind_q  <= t_kind;
			stat_q    <= in_stat;
			goal_q    <= t_ok && (t_kind == KIND_GOAL);
			pair_ok_q <= f_ok && t_ok;
			max_q     <= '0;
		end
		if (state_q == S_SCAN) begin
			// Read data trails the address: the Q table read is registered.
			if (scan_q == SCAN_Q_DATA) begin
				q_q <= pair_ok_q ? rdata_q : '0;
			end else if (scan_q > SCAN_Q_DATA && con_nb[NW] && t_kind_q != KIND_GOAL
				&& rdata_q > max_q) begin
				max_q <= rdata_q;
			end
		end
		if (state_q == S_MULG || state_q == S_MULA) begin
			prod_q <= mul_p;
		end
		if (state_q == S_DELTA) begin
			delta_q <= delta_d;
		end
		if (fin_noupd) begin
			res_q.status       <= stat_q;
			res_q.q_value      <= q_q;
			res_q.next_is_goal <= goal_q;
		end else if (fin_upd) begin
			res_q.status       <= STAT_UPDATED;
			res_q.q_value      <= q_sat;
			res_q.next_is_goal <= goal_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> rtl/gqlu_checker.sv
// Port checker for grid_q_learning_update, bound to the top level.
// Depends on grid_q_learning_update_assert.svh.
`include "grid_q_learning_update_assert.svh"

module gqlu_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// A result word is only shown once the block has gone idle again.
	`GQLU_ASSERT_SAME(a_done_idle, done, !busy, "result word shown while busy")

	// An accepted command keeps the block busy in the next cycle.
	`GQLU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "not busy after accept")

	// Each result word lasts exactly one cycle.
	`GQLU_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")

	// No result can follow an accepted command in the very next cycle.
	`GQLU_ASSERT_NEXT(a_no_early_done, start && !busy, !done, "result too early")

endmodule

bind grid_q_learning_update gqlu_checker u_gqlu_checker (.*);

>>> tb/sv/gqlu_tb_pkg.sv
// Scoreboard for the grid Q-learning update testbench: a bit-exact predictor of the
// Q update and a store of the result words still due. Depends on gqlu_pkg.
package gqlu_tb_pkg;
	import gqlu_pkg::*;

	localparam int ROWS  = 3;
	localparam int COLS  = 3;
	localparam int CELLS = ROWS * COLS;

	// Register indexes that the block does not decode.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	class qlearn_scoreboard;
		logic signed [31:0] q_table [CELLS*CELLS];
		logic [MAP_W-1:0]   maze;
		logic [15:0]        alpha;
		logic [15:0]        gamma;
		logic signed [15:0] r_goal;
		logic signed [15:0] r_wall;
		gqlu_result_t       results_due [$];
		int                 mismatches;

		function new();
			foreach (q_table[i]) q_table[i] = '0;
			maze       = MAZE_MAP_RST;
			alpha      = LEARN_RATE_RST;
			gamma      = DISCOUNT_RST;
			r_goal     = GOAL_REWARD_RST;
			r_wall     = WALL_REWARD_RST;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_MAZE_MAP:    maze   = d[MAP_W-1:0];
				REG_LEARN_RATE:  alpha  = d[15:0];
				REG_DISCOUNT:    gamma  = d[15:0];
				REG_GOAL_REWARD: r_goal = d[15:0];
				REG_WALL_REWARD: r_wall = d[15:0];
				default: ;
			endcase
		endfunction

		function logic [1:0] kind_of(int k);
			if (2 * k + 1 >= MAP_W)
				return KIND_OPEN;
			return maze[2*k +: 2];
		endfunction

		function bit neighbors(int a, int b);
			int dr;
			int dc;
			dr = a / COLS - b / COLS;
			dc = a % COLS - b % COLS;
			if (dr < 0) dr = -dr;
			if (dc < 0) dc = -dc;
			return dr + dc == 1;
		endfunction

		// Largest Q over the moves out of cell t, never below zero; a goal has no moves.
		function longint best_from(int t);
			longint best;
			best = 0;
			if (kind_of(t) == KIND_GOAL)
				return 0;
			for (int n = 0; n < CELLS; n++)
				if (neighbors(t, n) && q_table[t*CELLS+n] > best)
					best = longint'(q_table[t*CELLS+n]);
			return best;
		endfunction

		function void note_cmd(gqlu_cmd_t c);
			int           f;
			int           t;
			bit           f_ok;
			bit           t_ok;
			longint       q;
			longint       r;
			longint       gm;
			longint       delta;
			longint       step_l;
			longint       alpha_l;
			longint       gamma_l;
			gqlu_result_t w;
			f    = int'(c.from_cell);
			t    = int'(c.to_cell);
			f_ok = f < CELLS;
			t_ok = t < CELLS;
			q    = (f_ok && t_ok) ? longint'(q_table[f*CELLS+t]) : 0;
			w.next_is_goal = t_ok && kind_of(t) == KIND_GOAL;
			if (f_ok && kind_of(f) == KIND_GOAL) begin
				w.status = STAT_FROM_GOAL;
			end else if (!f_ok || !t_ok || !neighbors(f, t)) begin
				w.status = STAT_NOT_ADJ;
			end else begin
				if (kind_of(t) == KIND_GOAL)
					r = longint'(r_goal);
				else if (kind_of(t) != KIND_OPEN)
					r = longint'(r_wall);
				else
					r = 0;
				alpha_l = longint'(alpha);
				gamma_l = longint'(gamma);
				gm      = (gamma_l * best_from(t) + 32768) >>> 16;
				delta   = r * 65536 + gm - q;
				// Arithmetic shift floors, which gives round half up after the bias.
				step_l  = (alpha_l * delta + 32768) >>> 16;
				q       = q + step_l;
				if (q > longint'(Q_MAX)) q = longint'(Q_MAX);
				if (q < longint'(Q_MIN)) q = longint'(Q_MIN);
				q_table[f*CELLS+t] = 32'(q);
				w.status = STAT_UPDATED;
			end
			w.q_value = 32'(q);
			results_due = {results_due, w};
		endfunction

		function void flag(string what, longint want, longint got);
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH %s: expected %0d, got %0d", what, want, got);
		endfunction

		function void check_result(gqlu_result_t got);
			gqlu_result_t want;
			if (results_due.size() == 0) begin
				flag("unexpected result word, status", -1, got.status);
				return;
			end
			want = results_due.pop_front();
			if (got.status !== want.status)
				flag("status", want.status, got.status);
			if (got.q_value !== want.q_value)
				flag("q_value", want.q_value, got.q_value);
			if (got.next_is_goal !== want.next_is_goal)
				flag("next_is_goal", want.next_is_goal, got.next_is_goal);
		endfunction

		function int outstanding();
			return results_due.size();
		endfunction
	endclass

endpackage

>>> tb/sv/grid_q_learning_update_test.sv
// Top-level testbench of grid_q_learning_update: drives command words and register
// writes, checks every result word against gqlu_tb_pkg's scoreboard. Depends on
// gqlu_pkg and gqlu_tb_pkg.
module grid_q_learning_update_test;
	import gqlu_pkg::*;
	import gqlu_tb_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_ITEMS = 275;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  start = 1'b0;
	gqlu_cmd_t             cmd = '0;
	logic                  busy;
	logic                  done;
	gqlu_result_t          result;

	qlearn_scoreboard sb = new();
	int unsigned      cycles = 0;
	bit               idle_gaps = 1'b1;
	int               cursor = 0;

	grid_q_learning_update #(
		.GRID_ROWS(ROWS),
		.GRID_COLS(COLS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic issue(input gqlu_cmd_t c);
		int gap;
		gap = 0;
		if (idle_gaps && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 11);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		cmd   = c;
		do @(posedge clk); while (busy);
		sb.note_cmd(c);
		@(negedge clk);
	endtask

	// Holds off the sender until every result word is back and the block is idle.
	task automatic drain();
		start = 1'b0;
		while (sb.outstanding() > 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = d;
		@(posedge clk);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// The 16-bit registers get random bits above their width, which must be dropped.
	task automatic set_regs(input logic [17:0] map, input logic [15:0] lr,
		input logic [15:0] disc, input logic [15:0] goal, input logic [15:0] wall);
		drain();
		write_reg(REG_MAZE_MAP, map);
		write_reg(REG_LEARN_RATE, {2'($urandom), lr});
		write_reg(REG_DISCOUNT, {2'($urandom), disc});
		write_reg(REG_GOAL_REWARD, {2'($urandom), goal});
		write_reg(REG_WALL_REWARD, {2'($urandom), wall});
	endtask

	// Mostly walks of legal moves so the table fills up; the rest is noise.
	function automatic gqlu_cmd_t next_move();
		gqlu_cmd_t c;
		int        sel;
		int        to;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			c = gqlu_cmd_t'(8'($urandom));
		end else if (sel == 1) begin
			c.from_cell = CELL_IN_W'($urandom_range(0, CELLS - 1));
			c.to_cell   = CELL_IN_W'($urandom_range(0, CELLS - 1));
		end else begin
			if ($urandom_range(0, 11) == 0 ||
				(sb.kind_of(cursor) == KIND_GOAL && $urandom_range(0, 1) == 0))
				cursor = $urandom_range(0, CELLS - 1);
			to = -1;
			while (to < 0) begin
				case ($urandom_range(0, 3))
					NBR_UP:    if (cursor / COLS > 0) to = cursor - COLS;
					NBR_DOWN:  if (cursor / COLS < ROWS - 1) to = cursor + COLS;
					NBR_LEFT:  if (cursor % COLS > 0) to = cursor - 1;
					default:   if (cursor % COLS < COLS - 1) to = cursor + 1;
				endcase
			end
			c.from_cell = CELL_IN_W'(cursor);
			c.to_cell   = CELL_IN_W'(to);
			cursor      = to;
		end
		return c;
	endfunction

	// Default maze: cell 1 is the goal and cell 6 a wall.
	logic [7:0] directed [] = '{
		8'h01, 8'h01, 8'h03, 8'h36, 8'h43, 8'h41, 8'h01, 8'h10, 8'h12,
		8'h04, 8'h00, 8'h23, 8'h09, 8'h90, 8'hFF, 8'hF1, 8'h1F, 8'h0F,
		8'h87, 8'h85, 8'h45, 8'h47, 8'h30, 8'h63, 8'h01
	};

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			issue(gqlu_cmd_t'(directed[i]));

		// Writes to undecoded indexes must leave every register alone.
		drain();
		write_reg(REG_SPARE_LO, 18'($urandom));
		write_reg(REG_SPARE_HI, '1);
		for (int i = 0; i < 6; i++)
			issue(next_move());

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_regs(18'($urandom), 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000);
				1: set_regs(18'h3FFFF, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
				2: set_regs(18'h00000, 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
				default: set_regs(18'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				idle_gaps = (p != 5) && ((i / 40) % 2 == 0);
				issue(next_move());
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
